>>> hw/rtl/csem_pkg.sv
`default_nettype none
// -----------------------------------------------------------------------------
// csem_pkg: shared types and constants of the counting semaphore
// Sizes of the wait queue and the count, operation and status codes, state
// machine types and the command and result structs of the wait queue engine.
// -----------------------------------------------------------------------------
package csem_pkg;

   // Queue geometry and stored thread number width.
   localparam int QUEUE_DEPTH = 16;
   localparam int THREAD_BITS = 8;
   localparam int ENTRY_BITS  = (THREAD_BITS < 8) ? THREAD_BITS : 8;
   localparam int IDX_BITS    = (QUEUE_DEPTH > 2) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);

   // Semaphore count, two's complement.
   localparam int COUNT_BITS = 18;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {1'b0, {(COUNT_BITS-1){1'b1}}};

   // Operation codes carried in the request selector.
   typedef enum logic [2:0] {
      OP_OPEN     = 3'd0,
      OP_WAIT     = 3'd1,
      OP_SIGNAL   = 3'd2,
      OP_PRIO_SIG = 3'd3,
      OP_TRYWAIT  = 3'd4,
      OP_CLOSE    = 3'd5
   } csem_op_type;

   // Result status codes.
   typedef enum logic [2:0] {
      ST_PROCEED     = 3'd0,
      ST_BLOCKED     = 3'd1,
      ST_RELEASED    = 3'd2,
      ST_AVAILABLE   = 3'd3,
      ST_UNAVAILABLE = 3'd4,
      ST_FULL        = 3'd5
   } csem_status_type;

   // Top level sequencer states.
   typedef enum logic [1:0] {
      T_IDLE,
      T_REPLY,
      T_QUEUE
   } csem_tstate_type;

   // Wait queue engine states.
   typedef enum logic [2:0] {
      Q_IDLE,
      Q_SCAN,
      Q_SHIFT,
      Q_REPORT,
      Q_DRAIN
   } csem_qstate_type;

   // Wait queue engine commands.
   typedef enum logic [2:0] {
      Q_PUSH,
      Q_CLEAR,
      Q_TAKE_OLDEST,
      Q_TAKE_LOWEST,
      Q_DRAIN_ALL
   } csem_qop_type;

   typedef struct packed {
      logic                  valid;
      csem_qop_type          op;
      logic [ENTRY_BITS-1:0] data;
   } csem_qcmd_type;

   typedef struct packed {
      logic                  valid;
      logic                  last;
      logic [ENTRY_BITS-1:0] thread;
   } csem_qres_type;

endpackage
`default_nettype wire

>>> hw/rtl/csem_waitq.sv
`default_nettype none
// -----------------------------------------------------------------------------
// csem_waitq: wait queue engine of the counting semaphore
// Holds the blocked thread numbers in a small memory, oldest first. It pushes,
// clears, takes the oldest or the lowest entry (scan, then shift the rest
// down one slot a cycle) and drains the whole queue as a run of results.
// -----------------------------------------------------------------------------
module csem_waitq import csem_pkg::*; (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire csem_qcmd_type       cmd,
   input  wire logic                out_free,
   output csem_qres_type            res,
   output logic [CNT_BITS-1:0]      total
);

   csem_qstate_type       state_ff, state_in;
   logic [CNT_BITS-1:0]   total_ff, total_in;
   logic [IDX_BITS-1:0]   pend_ff;
   logic [IDX_BITS-1:0]   scan_ptr_ff, scan_ptr_in;
   logic [IDX_BITS-1:0]   best_idx_ff, best_idx_in;
   logic [ENTRY_BITS-1:0] best_val_ff, best_val_in;
   logic                  first_ff, first_in;
   logic                  lowest_ff, lowest_in;
   logic [ENTRY_BITS-1:0] rdata_ff;
   logic [ENTRY_BITS-1:0] mem [QUEUE_DEPTH];

   logic [IDX_BITS-1:0]   raddr;
   logic [IDX_BITS-1:0]   waddr;
   logic [ENTRY_BITS-1:0] wdata;
   logic                  we;
   logic [IDX_BITS-1:0]   last_idx;
   logic                  better;

   assign total    = total_ff;
   assign last_idx = IDX_BITS'(total_ff - 1'b1);

   // The one compare of the scan: first entry, or, when taking the lowest, a strictly lower number.
   assign better = first_ff || (lowest_ff && (rdata_ff < best_val_ff));

   // Queue memory with a registered read port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
      pend_ff  <= raddr;
   end

   // Sequencer registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= Q_IDLE;
         total_ff <= '0;
      end else begin
         state_ff <= state_in;
         total_ff <= total_in;
      end
      scan_ptr_ff <= scan_ptr_in;
      best_idx_ff <= best_idx_in;
      best_val_ff <= best_val_in;
      first_ff    <= first_in;
      lowest_ff   <= lowest_in;
   end

   // Next state, memory port control and results.
   always_comb begin
      state_in    = state_ff;
      total_in    = total_ff;
      scan_ptr_in = scan_ptr_ff;
      best_idx_in = best_idx_ff;
      best_val_in = best_val_ff;
      first_in    = first_ff;
      lowest_in   = lowest_ff;
      raddr       = scan_ptr_ff;
      we          = 1'b0;
      waddr       = IDX_BITS'(total_ff);
      wdata       = cmd.data;
      res         = '0;

      unique case (state_ff)
         Q_IDLE: begin
            if (cmd.valid) begin
               unique case (cmd.op)
                  Q_PUSH: begin
                     we       = 1'b1;
                     total_in = total_ff + 1'b1;
                  end
                  Q_CLEAR: begin
                     total_in = '0;
                  end
                  Q_TAKE_OLDEST, Q_TAKE_LOWEST: begin
                     raddr       = '0;
                     scan_ptr_in = IDX_BITS'(1);
                     first_in    = 1'b1;
                     lowest_in   = (cmd.op == Q_TAKE_LOWEST);
                     state_in    = Q_SCAN;
                  end
                  Q_DRAIN_ALL: begin
                     raddr    = '0;
                     state_in = Q_DRAIN;
                  end
                  default: begin
                  end
               endcase
            end
         end

         Q_SCAN: begin
            // The entry read last cycle is compared against the best so far.
            first_in    = 1'b0;
            scan_ptr_in = scan_ptr_ff + 1'b1;
            if (better) begin
               best_idx_in = pend_ff;
               best_val_in = rdata_ff;
            end
            if (pend_ff == last_idx) begin
               if (best_idx_in == last_idx) begin
                  total_in = total_ff - 1'b1;
                  state_in = Q_REPORT;
               end else begin
                  raddr    = best_idx_in + 1'b1;
                  state_in = Q_SHIFT;
               end
            end
         end

         Q_SHIFT: begin
            // Move the entry just read down one slot and fetch the next.
            we    = 1'b1;
            waddr = pend_ff - 1'b1;
            wdata = rdata_ff;
            raddr = pend_ff + 1'b1;
            if (pend_ff == last_idx) begin
               total_in = total_ff - 1'b1;
               state_in = Q_REPORT;
            end
         end

         Q_REPORT: begin
            res.valid  = 1'b1;
            res.last   = 1'b1;
            res.thread = best_val_ff;
            if (out_free) begin
               state_in = Q_IDLE;
            end
         end

         Q_DRAIN: begin
            // Re-read the same entry while the output is stalled.
            res.valid  = 1'b1;
            res.last   = (pend_ff == last_idx);
            res.thread = rdata_ff;
            raddr      = out_free ? (pend_ff + 1'b1) : pend_ff;
            if (out_free && res.last) begin
               total_in = '0;
               state_in = Q_IDLE;
            end
         end

         default: begin
            state_in = Q_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

>>> hw/rtl/counting_semaphore_wait_queue.sv
`default_nettype none
// -----------------------------------------------------------------------------
// counting_semaphore_wait_queue: counting semaphore with a thread wait queue
// Open, wait, signal, priority signal, trywait and close operations on one
// semaphore count, with blocked thread numbers kept in a wait queue.
//
//   Channel   Direction  Handshake            Payload
//   req_      in         tvalid/tready        tuser opcode, tdata thread/init
//   rsp_      out        tvalid/tready/tlast  tuser status, tdata thread
//
// One request at a time; req_tready is high only in the idle state.
// A release scans all N queued entries and shifts those above the chosen
// one at position pos down. Close with N waiters gives N results. The queue
// memory has a single read port; output stalls hold the results.
// Synchronous active-high reset empties the queue and zeroes the count.
// -----------------------------------------------------------------------------
module counting_semaphore_wait_queue import csem_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,   // [7:0] thread_id, [23:8] init_value
   input  wire logic [2:0]  req_tuser,   // [2:0] opcode
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,   // [7:0] released_thread
   output logic [2:0]       rsp_tuser,   // [2:0] status
   output logic             rsp_tlast
);

   csem_tstate_type       state_ff, state_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   csem_status_type       reply_ff, reply_in;

   logic                  rsp_valid_ff;
   csem_status_type       rsp_status_ff;
   logic [7:0]            rsp_thread_ff;
   logic                  rsp_last_ff;

   logic                  load_rsp;
   csem_status_type       load_status;
   logic [7:0]            load_thread;
   logic                  load_last;

   csem_op_type           op;
   logic [ENTRY_BITS-1:0] tid;
   logic [15:0]           init_value;
   logic                  out_free;
   logic [COUNT_BITS-1:0] count_step;
   logic [COUNT_BITS-1:0] count_inc;
   logic                  count_pos;
   logic                  inc_nonpos;
   logic                  queue_full;

   csem_qcmd_type         q_cmd;
   csem_qres_type         q_res;
   logic [CNT_BITS-1:0]   q_total;

   // Request fields.
   assign op         = csem_op_type'(req_tuser);
   assign tid        = ENTRY_BITS'(req_tdata[7:0]);
   assign init_value = req_tdata[23:8];

   assign req_tready = (state_ff == T_IDLE);
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // The shared count unit: one increment or decrement, and its tests.
   assign count_step = count_ff + ((op == OP_WAIT) ? '1 : COUNT_BITS'(1));
   assign count_inc  = (count_ff != COUNT_MAX) ? count_step : count_ff;
   assign count_pos  = !count_ff[COUNT_BITS-1] && (count_ff != '0);
   assign inc_nonpos = count_inc[COUNT_BITS-1] || (count_inc == '0);
   assign queue_full = (q_total == CNT_BITS'(QUEUE_DEPTH));

   // Wait queue engine.
   csem_waitq u_waitq (
      .clock    (clock),
      .reset    (reset),
      .cmd      (q_cmd),
      .out_free (out_free),
      .res      (q_res),
      .total    (q_total)
   );

   // Sequencer state, count and pending reply.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= T_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      reply_ff <= reply_in;
   end

   // Operation decode and sequencing.
   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      reply_in    = reply_ff;
      q_cmd       = '0;
      load_rsp    = 1'b0;
      load_status = ST_PROCEED;
      load_thread = '0;
      load_last   = 1'b1;

      unique case (state_ff)
         T_IDLE: begin
            if (req_tvalid) begin
               state_in = T_REPLY;
               reply_in = ST_PROCEED;
               case (op)
                  OP_OPEN: begin
                     count_in    = COUNT_BITS'(init_value);
                     q_cmd.valid = 1'b1;
                     q_cmd.op    = Q_CLEAR;
                  end
                  OP_WAIT: begin
                     if (count_pos) begin
                        count_in = count_step;
                     end else if (queue_full) begin
                        reply_in = ST_FULL;
                     end else begin
                        count_in    = count_step;
                        q_cmd.valid = 1'b1;
                        q_cmd.op    = Q_PUSH;
                        q_cmd.data  = tid;
                        reply_in    = ST_BLOCKED;
                     end
                  end
                  OP_SIGNAL, OP_PRIO_SIG: begin
                     count_in = count_inc;
                     if (inc_nonpos && (q_total != '0)) begin
                        q_cmd.valid = 1'b1;
                        q_cmd.op    = (op == OP_PRIO_SIG) ? Q_TAKE_LOWEST : Q_TAKE_OLDEST;
                        state_in    = T_QUEUE;
                     end
                  end
                  OP_TRYWAIT: begin
                     reply_in = count_pos ? ST_AVAILABLE : ST_UNAVAILABLE;
                  end
                  OP_CLOSE: begin
                     count_in = '0;
                     if (q_total != '0) begin
                        q_cmd.valid = 1'b1;
                        q_cmd.op    = Q_DRAIN_ALL;
                        state_in    = T_QUEUE;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         T_REPLY: begin
            if (out_free) begin
               load_rsp    = 1'b1;
               load_status = reply_ff;
               state_in    = T_IDLE;
            end
         end

         T_QUEUE: begin
            if (q_res.valid && out_free) begin
               load_rsp    = 1'b1;
               load_status = ST_RELEASED;
               load_thread = 8'(q_res.thread);
               load_last   = q_res.last;
               if (q_res.last) begin
                  state_in = T_IDLE;
               end
            end
         end

         default: begin
            state_in = T_IDLE;
         end
      endcase
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (load_rsp) begin
         rsp_status_ff <= load_status;
         rsp_thread_ff <= load_thread;
         rsp_last_ff   <= load_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = rsp_thread_ff;
   assign rsp_tlast  = rsp_last_ff;

   // While idle and the count is negative, the queue holds minus count waiters.
   a_count_matches_queue : assert property (@(posedge clock) disable iff (reset)
      ((state_ff == T_IDLE) && count_ff[COUNT_BITS-1])
         |-> (COUNT_BITS'(q_total) == (~count_ff + 1'b1)))
      else $error("wait queue size does not match negative count");

   // The queue engine only offers results while the sequencer waits for them.
   a_no_stray_queue_result : assert property (@(posedge clock) disable iff (reset)
      (state_ff != T_QUEUE) |-> !q_res.valid)
      else $error("queue result offered outside a release or close");

   // Only a close gives results that are not the last of their request.
   a_multi_only_release : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_last_ff) |-> (rsp_status_ff == ST_RELEASED))
      else $error("non-final result that is not a release");

endmodule
`default_nettype wire
